FILE: hdl/wsd_pkg.sv
package wsd_pkg;

	typedef enum logic [4:0] {
		PH_HDR0    = 5'b00001,
		PH_HDR1    = 5'b00010,
		PH_EXTLEN  = 5'b00100,
		PH_MASK    = 5'b01000,
		PH_PAYLOAD = 5'b10000
	} wsd_phase_t;

	typedef struct packed {
		logic [7:0] payload_byte;
		logic       data_valid;
		logic [3:0] opcode;
		logic       fin;
		logic [2:0] rsv;
		logic       masked;
		logic       frame_end;
	} wsd_result_t;

	localparam logic [6:0] LEN7_EXT16 = 7'd126;
	localparam logic [6:0] LEN7_EXT64 = 7'd127;
	localparam logic [3:0] EXT16_BYTES = 4'd2;
	localparam logic [3:0] EXT64_BYTES = 4'd8;
	localparam logic [2:0] KEY_BYTES = 3'd4;

endpackage

FILE: hdl/wsd_parser.sv
module wsd_parser
	import wsd_pkg::*;
#(
	parameter int LENGTH_WIDTH = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  logic [7:0]        rx_byte,
	output logic              res_valid,
	output wsd_result_t       res
);

	wsd_phase_t              phase_q, phase_n;
	logic [3:0]              opcode_q, opcode_n;
	logic                    fin_q, fin_n;
	logic [2:0]              rsv_q, rsv_n;
	logic                    masked_q, masked_n;
	logic [3:0]              len_left_q, len_left_n;
	logic [31:0]             key_q, key_n;
	logic [2:0]              key_left_q, key_left_n;
	logic [LENGTH_WIDTH-1:0] rem_q, rem_n;
	logic                    over_q, over_n;
	logic [1:0]              off_q, off_n;
	logic [7:0]              key_byte;
	logic                    finish;
	logic                    from_mask;

	always_comb begin
		unique case (off_q)
			2'd0: key_byte = key_q[31:24];
			2'd1: key_byte = key_q[23:16];
			2'd2: key_byte = key_q[15:8];
			2'd3: key_byte = key_q[7:0];
		endcase
	end

	always_comb begin
		phase_n    = phase_q;
		opcode_n   = opcode_q;
		fin_n      = fin_q;
		rsv_n      = rsv_q;
		masked_n   = masked_q;
		len_left_n = len_left_q;
		key_n      = key_q;
		key_left_n = key_left_q;
		rem_n      = rem_q;
		over_n     = over_q;
		off_n      = off_q;
		finish     = 1'b0;
		from_mask  = 1'b0;
		res_valid  = 1'b0;
		res        = '0;
		unique case (phase_q)
			PH_HDR1: begin
				masked_n = rx_byte[7];
				over_n   = 1'b0;
				if (rx_byte[6:0] == LEN7_EXT16) begin
					rem_n      = '0;
					len_left_n = EXT16_BYTES;
					phase_n    = PH_EXTLEN;
				end else if (rx_byte[6:0] == LEN7_EXT64) begin
					rem_n      = '0;
					len_left_n = EXT64_BYTES;
					phase_n    = PH_EXTLEN;
				end else begin
					rem_n  = {{(LENGTH_WIDTH-7){1'b0}}, rx_byte[6:0]};
					finish = 1'b1;
				end
			end
			PH_EXTLEN: begin
				rem_n      = {rem_q[LENGTH_WIDTH-9:0], rx_byte};
				over_n     = over_q | (rem_q[LENGTH_WIDTH-1 -: 8] != 8'd0);
				len_left_n = len_left_q - 4'd1;
				if (len_left_n == 4'd0) begin
					if (over_n) begin
						rem_n = '1;
					end
					finish = 1'b1;
				end
			end
			PH_MASK: begin
				key_n      = {key_q[23:0], rx_byte};
				key_left_n = key_left_q - 3'd1;
				from_mask  = 1'b1;
				if (key_left_n == 3'd0) begin
					finish = 1'b1;
				end
			end
			PH_PAYLOAD: begin
				off_n     = off_q + 2'd1;
				rem_n     = rem_q - {{(LENGTH_WIDTH-1){1'b0}}, 1'b1};
				res_valid = 1'b1;
				res.payload_byte = rx_byte ^ key_byte;
				res.data_valid   = 1'b1;
				res.frame_end    = (rem_q == {{(LENGTH_WIDTH-1){1'b0}}, 1'b1});
				if (res.frame_end) begin
					phase_n = PH_HDR0;
				end
			end
			default: begin
				opcode_n   = rx_byte[3:0];
				fin_n      = rx_byte[7];
				rsv_n      = rx_byte[6:4];
				masked_n   = 1'b0;
				key_n      = '0;
				key_left_n = '0;
				len_left_n = '0;
				rem_n      = '0;
				off_n      = '0;
				phase_n    = PH_HDR1;
			end
		endcase
		if (finish) begin
			off_n = '0;
			if (masked_n && !from_mask) begin
				key_n      = '0;
				key_left_n = KEY_BYTES;
				phase_n    = PH_MASK;
			end else if (rem_n == '0) begin
				phase_n       = PH_HDR0;
				res_valid     = 1'b1;
				res.frame_end = 1'b1;
			end else begin
				phase_n = PH_PAYLOAD;
			end
		end
		res.opcode = opcode_n;
		res.fin    = fin_n;
		res.rsv    = rsv_n;
		res.masked = masked_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_HDR0;
			opcode_q   <= '0;
			fin_q      <= 1'b0;
			rsv_q      <= '0;
			masked_q   <= 1'b0;
			len_left_q <= '0;
			key_q      <= '0;
			key_left_q <= '0;
			rem_q      <= '0;
			over_q     <= 1'b0;
			off_q      <= '0;
		end else if (accept) begin
			phase_q    <= phase_n;
			opcode_q   <= opcode_n;
			fin_q      <= fin_n;
			rsv_q      <= rsv_n;
			masked_q   <= masked_n;
			len_left_q <= len_left_n;
			key_q      <= key_n;
			key_left_q <= key_left_n;
			rem_q      <= rem_n;
			over_q     <= over_n;
			off_q      <= off_n;
		end
	end

endmodule

FILE: hdl/wsd_out_skid.sv
module wsd_out_skid
	import wsd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  wsd_result_t in_res,
	output logic        full,
	output logic        out_valid,
	input  logic        out_stall,
	output wsd_result_t out_res
);

	logic        out_valid_q;
	wsd_result_t out_res_q;
	logic        skid_valid_q;
	wsd_result_t skid_res_q;

	assign full      = skid_valid_q;
	assign out_valid = out_valid_q;
	assign out_res   = out_res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || !out_stall) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= in_valid;
			end
		end else if (in_valid) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || !out_stall) begin
			out_res_q <= skid_valid_q ? skid_res_q : in_res;
		end else if (in_valid) begin
			skid_res_q <= in_res;
		end
	end

endmodule

FILE: hdl/websocket_frame_deframer.sv
// WebSocket frame deframer for the receive side of a connection.
// The input channel (in_valid, in_stall, rx_byte) carries the received
// stream, one byte per word. The output channel (out_valid, out_stall and
// the result fields) carries one word per payload byte, already unmasked,
// together with the opcode, fin, reserved bits and mask flag of its frame.
// Header, extended length and mask key bytes produce no output word.
// A frame with zero length produces one word with data_valid low and
// frame_end high once its header and key are complete.
// An input word is parsed in the cycle it is accepted, and its result is
// registered into the output word, or into the skid register if stalled.
// Throughput is one input byte per clock cycle while in_stall is low, set
// by the single header and length parse stage that holds the frame state.
// When the receiver stalls, the output word holds and one further result
// is kept in a skid register; in_stall rises while that register is full.
// Reset clears the frame state, so the next byte is taken as the first
// header byte of a new frame, and empties the output stage.
module websocket_frame_deframer
	import wsd_pkg::*;
#(
	parameter int LENGTH_WIDTH = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] rx_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] payload_byte,
	output logic       data_valid,
	output logic [3:0] frame_opcode_out,
	output logic       frame_fin_out,
	output logic [2:0] frame_rsv_out,
	output logic       frame_masked_out,
	output logic       frame_end
);

	logic        accept;
	logic        res_valid;
	wsd_result_t res;
	wsd_result_t out_res;

	assign accept = in_valid && !in_stall;

	wsd_parser #(
		.LENGTH_WIDTH(LENGTH_WIDTH)
	) u_parser (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.rx_byte  (rx_byte),
		.res_valid(res_valid),
		.res      (res)
	);

	wsd_out_skid u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (accept && res_valid),
		.in_res   (res),
		.full     (in_stall),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_res  (out_res)
	);

	assign payload_byte     = out_res.payload_byte;
	assign data_valid       = out_res.data_valid;
	assign frame_opcode_out = out_res.opcode;
	assign frame_fin_out    = out_res.fin;
	assign frame_rsv_out    = out_res.rsv;
	assign frame_masked_out = out_res.masked;
	assign frame_end        = out_res.frame_end;

endmodule

FILE: hdl/wsd_checker.sv
module wsd_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic [7:0] rx_byte,
	input logic       out_valid,
	input logic       out_stall,
	input logic [7:0] payload_byte,
	input logic       data_valid,
	input logic [3:0] frame_opcode_out,
	input logic       frame_fin_out,
	input logic [2:0] frame_rsv_out,
	input logic       frame_masked_out,
	input logic       frame_end
);

	// A word without data is always the single word of an empty frame.
	a_empty_ends: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !data_valid |-> frame_end && payload_byte == 8'd0)
		else $error("word without data is not an end of frame");

	// The input only stalls while the output holds a word.
	a_stall_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid)
		else $error("input stalled while output is empty");

	// The input stalls only after the output stalled with a word waiting.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(in_stall) |-> $past(out_valid && out_stall))
		else $error("input stall without a stalled output");

	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_stall |=> in_valid && $stable(rx_byte))
		else $error("stalled input word changed");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(payload_byte)
			&& $stable(frame_end) && $stable(data_valid)
			&& $stable(frame_opcode_out) && $stable(frame_fin_out)
			&& $stable(frame_rsv_out) && $stable(frame_masked_out))
		else $error("stalled output word changed");

endmodule

bind websocket_frame_deframer wsd_checker u_wsd_checker (.*);
